// File: sv/ofsa_pkg.sv
// Shared types, codes and register constants of the oxygen flow stall alarm.
`default_nettype none

package ofsa_pkg;

   // Alarm state encoding shared by the own alarm and both supply alarms.
   localparam logic [2:0] ALM_FALSE     = 3'd0;
   localparam logic [2:0] ALM_TRUE      = 3'd2;
   localparam logic [2:0] ALM_DISPLAYED = 3'd3;

   // Breath phase encoding.
   localparam logic [2:0] PHASE_DISABLED  = 3'd0;
   localparam logic [2:0] PHASE_INSP_CTRL = 3'd1;
   localparam logic [2:0] PHASE_INSP_TRIG = 3'd2;
   localparam logic [2:0] PHASE_EXHALE    = 3'd3;

   // Configuration register map, one 32-bit word per register.
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam logic [1:0] REG_MIN_OXYGEN    = 2'd0;
   localparam logic [1:0] REG_CYCLES_NEEDED = 2'd1;
   localparam logic [1:0] REG_FLOW_TOL      = 2'd2;

   localparam logic [6:0]  MIN_OXYGEN_RESET    = 7'd21;
   localparam logic [3:0]  CYCLES_NEEDED_RESET = 4'd3;
   localparam logic [14:0] FLOW_TOL_RESET      = 15'd1;

   localparam logic [3:0] COUNT_MAX = 4'd15;

   typedef struct packed {
      logic [6:0]  min_oxygen_setting;
      logic [3:0]  cycles_needed;
      logic [14:0] flow_tolerance;
   } cfg_type;

   // Input item without the flow sample, whose width is a parameter.
   typedef struct packed {
      logic [2:0] alarm_state;
      logic [2:0] supply_check_alarm;
      logic [2:0] supply_missing_alarm;
      logic [2:0] breath_phase;
      logic [6:0] oxygen_setting;
      logic       full_oxygen_active;
      logic       calibration_running;
   } item_type;

   typedef struct packed {
      logic raise_alarm;
      logic clear_alarm;
      logic error_flag;
   } result_type;

   function automatic logic is_insp(input logic [2:0] phase);
      is_insp = (phase == PHASE_INSP_CTRL) || (phase == PHASE_INSP_TRIG);
   endfunction

endpackage

`default_nettype wire

// File: sv/ofsa_csr.sv
// Configuration registers of the oxygen flow stall alarm behind an APB-style port.
`default_nettype none

module ofsa_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [ofsa_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [31:0]                          pwdata,
   output logic      [31:0]                          prdata,
   output logic                                      pready,
   output ofsa_pkg::cfg_type                         cfg
);

   logic [6:0]  min_oxygen_ff;
   logic [3:0]  cycles_needed_ff;
   logic [14:0] flow_tol_ff;
   logic        wr_en;
   logic [1:0]  reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_oxygen_ff    <= ofsa_pkg::MIN_OXYGEN_RESET;
         cycles_needed_ff <= ofsa_pkg::CYCLES_NEEDED_RESET;
         flow_tol_ff      <= ofsa_pkg::FLOW_TOL_RESET;
      end else if (wr_en) begin
         unique case (reg_index)
            ofsa_pkg::REG_MIN_OXYGEN:    min_oxygen_ff    <= pwdata[6:0];
            ofsa_pkg::REG_CYCLES_NEEDED: cycles_needed_ff <= pwdata[3:0];
            ofsa_pkg::REG_FLOW_TOL:      flow_tol_ff      <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         ofsa_pkg::REG_MIN_OXYGEN:    prdata = {25'd0, min_oxygen_ff};
         ofsa_pkg::REG_CYCLES_NEEDED: prdata = {28'd0, cycles_needed_ff};
         ofsa_pkg::REG_FLOW_TOL:      prdata = {17'd0, flow_tol_ff};
         default:                     prdata = 32'd0;
      endcase
   end

   assign cfg.min_oxygen_setting = min_oxygen_ff;
   assign cfg.cycles_needed      = cycles_needed_ff;
   assign cfg.flow_tolerance     = flow_tol_ff;

endmodule

`default_nettype wire

// File: sv/ofsa_core.sv
// Breath tracking state and alarm decision logic of the oxygen flow stall alarm.
`default_nettype none

module ofsa_core #(
   parameter int FLOW_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire ofsa_pkg::item_type          item,
   input  wire logic signed [FLOW_BITS-1:0] flow,
   input  wire ofsa_pkg::cfg_type           cfg,
   output ofsa_pkg::result_type             result
);

   // Wide enough for peak minus trough and for the zero-extended tolerance.
   localparam int SW = (FLOW_BITS + 2 > 17) ? FLOW_BITS + 2 : 17;

   logic [2:0]                  prev_phase_ff, prev_phase_in;
   logic [3:0]                  count_ff, count_in;
   logic signed [FLOW_BITS-1:0] trough_ff, trough_in;
   logic signed [FLOW_BITS-1:0] peak_ff, peak_in;

   logic signed [FLOW_BITS-1:0] peak_trk, trough_trk;
   logic signed [SW-1:0]        swing, tol_ext;
   logic                        flat, o2_wanted, breath_end, good_breath;
   logic [3:0]                  count_upd;

   always_comb begin
      // Peak follows inspiration, trough follows exhalation and never goes negative.
      peak_trk = peak_ff;
      if (ofsa_pkg::is_insp(item.breath_phase) && (peak_ff < flow)) begin
         peak_trk = flow;
      end
      trough_trk = trough_ff;
      if (item.breath_phase == ofsa_pkg::PHASE_EXHALE) begin
         if (trough_ff > flow) begin
            trough_trk = flow;
         end
         if (trough_trk < 0) begin
            trough_trk = '0;
         end
      end

      swing   = SW'(peak_trk) - SW'(trough_trk);
      tol_ext = $signed({{(SW-15){1'b0}}, cfg.flow_tolerance});
      flat    = (swing <= tol_ext);

      o2_wanted  = (item.oxygen_setting > cfg.min_oxygen_setting) || item.full_oxygen_active;
      breath_end = ofsa_pkg::is_insp(prev_phase_ff) &&
                   (item.breath_phase == ofsa_pkg::PHASE_EXHALE);
      good_breath = flat && o2_wanted &&
                    (item.supply_check_alarm == ofsa_pkg::ALM_FALSE) &&
                    (item.supply_missing_alarm == ofsa_pkg::ALM_FALSE) &&
                    !item.calibration_running;

      prev_phase_in = item.breath_phase;
      peak_in       = peak_trk;
      trough_in     = trough_trk;
      count_in      = count_ff;
      count_upd     = count_ff;
      result        = '0;

      unique case (item.alarm_state)
         ofsa_pkg::ALM_FALSE: begin
            if (breath_end) begin
               if (good_breath) begin
                  if ((count_ff <= cfg.cycles_needed) && (count_ff != ofsa_pkg::COUNT_MAX)) begin
                     count_upd = count_ff + 4'd1;
                  end
               end else begin
                  count_upd = '0;
               end
               trough_in = peak_trk;
               peak_in   = '0;
            end
            // The count is checked on every tick in the false state.
            if (count_upd == cfg.cycles_needed) begin
               count_in           = '0;
               result.raise_alarm = 1'b1;
            end else begin
               count_in = count_upd;
            end
         end
         ofsa_pkg::ALM_TRUE: begin
         end
         ofsa_pkg::ALM_DISPLAYED: begin
            result.clear_alarm = !flat || !o2_wanted ||
                                 (item.supply_check_alarm >= ofsa_pkg::ALM_TRUE) ||
                                 (item.supply_missing_alarm >= ofsa_pkg::ALM_TRUE) ||
                                 item.calibration_running;
         end
         default: begin
            result.error_flag = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phase_ff <= ofsa_pkg::PHASE_DISABLED;
         count_ff      <= '0;
         trough_ff     <= '0;
         peak_ff       <= '0;
      end else if (step) begin
         prev_phase_ff <= prev_phase_in;
         count_ff      <= count_in;
         trough_ff     <= trough_in;
         peak_ff       <= peak_in;
      end
   end

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      step |-> $onehot0({result.raise_alarm, result.clear_alarm, result.error_flag}))
      else $error("more than one alarm action in one result");

   a_raise_clears_count: assert property (@(posedge clock) disable iff (reset)
      step && result.raise_alarm |=> count_ff == 4'd0)
      else $error("breath count not cleared after raising the alarm");

   a_phase_follows: assert property (@(posedge clock) disable iff (reset)
      step |=> prev_phase_ff == $past(item.breath_phase))
      else $error("previous phase does not follow the accepted item");

   a_trough_not_negative: assert property (@(posedge clock) disable iff (reset)
      step && (item.breath_phase == ofsa_pkg::PHASE_EXHALE) && !breath_end |=> trough_ff >= 0)
      else $error("trough negative after an exhalation tick");

endmodule

`default_nettype wire

// File: sv/oxygen_flow_stall_alarm.sv
// Top level of the oxygen flow stall alarm: item pipeline, result register and CSRs.
`default_nettype none

// The oxygen flow stall alarm watches one monitoring tick per item. Each item
// carries the flow sample, breath phase, the own and supply alarm states, the
// oxygen setting and the full-oxygen and calibration flags; each item yields
// exactly one result with raise_alarm, clear_alarm and error_flag. The block
// tracks the inspiratory peak and the expiratory trough (clamped at zero) and
// counts consecutive flat breaths at each inspiration-to-exhalation change
// while the alarm is false; reaching cycles_needed raises the alarm, and in
// the displayed state a lost condition clears it. An item is registered on
// acceptance, evaluated against the breath state when it leaves the input
// register and its result is registered, so rsp_valid rises at the edge
// that moves it to the result register; one item is accepted in every
// cycle while rsp_ready is high.
// The result register lets a new item enter while a finished result waits.
// Configuration registers (min_oxygen_setting at 0x0, cycles_needed at 0x4,
// flow_tolerance at 0x8) are written through the APB-style port and should
// only be changed while no item is in flight. The priority-bit updates
// (set 0x0040, clear with mask 0xFFBF) belong to the consumer of the result.

module oxygen_flow_stall_alarm #(
   parameter int FLOW_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Item input channel.
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [2:0]                          req_alarm_state,
   input  wire logic [2:0]                          req_supply_check_alarm,
   input  wire logic [2:0]                          req_supply_missing_alarm,
   input  wire logic signed [FLOW_BITS-1:0]         req_oxygen_flow,
   input  wire logic [2:0]                          req_breath_phase,
   input  wire logic [6:0]                          req_oxygen_setting,
   input  wire logic                                req_full_oxygen_active,
   input  wire logic                                req_calibration_running,
   // Result channel.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_raise_alarm,
   output logic                                     rsp_clear_alarm,
   output logic                                     rsp_error_flag,
   // Configuration port.
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [ofsa_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [31:0]                         pwdata,
   output logic      [31:0]                         prdata,
   output logic                                     pready
);

   ofsa_pkg::cfg_type           cfg;
   ofsa_pkg::item_type          req_item;
   ofsa_pkg::item_type          s1_item_ff;
   logic signed [FLOW_BITS-1:0] s1_flow_ff;
   logic                        s1_valid_ff;
   logic                        s1_advance;
   ofsa_pkg::result_type        core_result;
   ofsa_pkg::result_type        rsp_result_ff;
   logic                        rsp_valid_ff;

   ofsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_item.alarm_state          = req_alarm_state;
   assign req_item.supply_check_alarm   = req_supply_check_alarm;
   assign req_item.supply_missing_alarm = req_supply_missing_alarm;
   assign req_item.breath_phase         = req_breath_phase;
   assign req_item.oxygen_setting       = req_oxygen_setting;
   assign req_item.full_oxygen_active   = req_full_oxygen_active;
   assign req_item.calibration_running  = req_calibration_running;

   // The registered item is evaluated and leaves the input stage as soon as the
   // result register is empty or is being emptied in the same cycle.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_item;
         s1_flow_ff <= req_oxygen_flow;
      end
      if (s1_advance) begin
         rsp_result_ff <= core_result;
      end
   end

   // Breath state advances exactly once per item, when it moves to the result.
   ofsa_core #(
      .FLOW_BITS (FLOW_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (s1_advance),
      .item   (s1_item_ff),
      .flow   (s1_flow_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_raise_alarm = rsp_result_ff.raise_alarm;
   assign rsp_clear_alarm = rsp_result_ff.clear_alarm;
   assign rsp_error_flag  = rsp_result_ff.error_flag;

endmodule

`default_nettype wire
